[rtl/jcam_pkg.sv]
// Shared types and constants for the joystick calibrate and angle map unit.
// No dependencies; imported by every module of the block.
package jcam_pkg;

  localparam int POS_W   = 8;
  localparam int ANGLE_W = 15;
  localparam int FS_W    = 7;
  localparam int CNT_W   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  // dividend carries one spare top bit so the quotient comes out two bits a cycle
  localparam int DIV_NUM_W  = 16;
  localparam int DIV_CNT_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_TOL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_THRESH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOPS_REQ  = 3'd5;

  localparam logic [POS_W-1:0] RST_CENTRE_TOL = 8'd5;
  localparam logic [POS_W-1:0] RST_FAR_THRESH = 8'd70;
  localparam logic [FS_W-1:0]  RST_FULL_SCALE = 7'd60;
  localparam logic [POS_W-1:0] RST_DEAD_ZONE  = 8'd10;
  localparam logic [CNT_W-1:0] RST_WARMUP     = 4'd10;
  localparam logic [CNT_W-1:0] RST_LOOPS_REQ  = 4'd3;

  localparam logic [CNT_W-1:0] DIR_TOP   = 4'b0001;
  localparam logic [CNT_W-1:0] DIR_RIGHT = 4'b0010;
  localparam logic [CNT_W-1:0] DIR_DOWN  = 4'b0100;
  localparam logic [CNT_W-1:0] DIR_LEFT  = 4'b1000;
  localparam logic [CNT_W-1:0] DIR_ALL   = 4'b1111;

  localparam logic [ANGLE_W-1:0] ANGLE_POS_MAX = 15'd16383;
  localparam logic [ANGLE_W-1:0] ANGLE_NEG_MAX = 15'd16384;

  typedef enum logic [1:0] {
    MODE_WARMUP = 2'd0,
    MODE_CAL    = 2'd1,
    MODE_RUN    = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PITCH_GO,
    ST_PITCH_WAIT,
    ST_ROLL_GO,
    ST_ROLL_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [POS_W-1:0] centre_tol;
    logic [POS_W-1:0] far_thresh;
    logic [POS_W-1:0] dead_zone;
    logic [CNT_W-1:0] warmup;
    logic [CNT_W-1:0] loops_req;
  } cfg_t;

  // per-axis operands for the angle division
  typedef struct packed {
    logic [POS_W-1:0] mag;
    logic             neg;
    logic [POS_W-1:0] range;
    logic             zero;
  } axis_job_t;

  typedef struct packed {
    mode_t            phase;
    logic [CNT_W-1:0] loops;
    logic [CNT_W-1:0] mask;
    logic             moved;
    axis_job_t        x;
    axis_job_t        y;
  } job_t;

endpackage

[rtl/jcam_track.sv]
// Calibration tracker: warmup count, centre capture, extremes, gesture bits, loops.
// Depends on jcam_pkg; produces the per-word job for the angle sequencer.
module jcam_track
  import jcam_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             accept,
  input  logic [POS_W-1:0] x_pos,
  input  logic [POS_W-1:0] y_pos,
  input  logic             restart,
  output job_t             job
);

  mode_t            mode_r, mode_nxt, mode_cur;
  logic [CNT_W-1:0] wc_r, wc_nxt, wc_cur;
  logic [CNT_W-1:0] mask_r, mask_nxt, mask_cur, mask_or;
  logic [CNT_W-1:0] loops_r, loops_nxt, loops_cur;
  logic [POS_W-1:0] xc_r, xc_nxt, yc_r, yc_nxt;
  logic [POS_W-1:0] xl_r, xl_nxt, xh_r, xh_nxt;
  logic [POS_W-1:0] yl_r, yl_nxt, yh_r, yh_nxt;
  logic [POS_W-1:0] dx_mag, dy_mag;
  logic             dx_neg, dy_neg, dx_pos, dy_pos;
  logic             x_ctr, y_ctr, x_far, y_far;
  logic [CNT_W-1:0] dir_bit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_WARMUP;
      wc_r    <= '0;
      mask_r  <= '0;
      loops_r <= '0;
      xc_r    <= '0;
      yc_r    <= '0;
      xl_r    <= '0;
      xh_r    <= '0;
      yl_r    <= '0;
      yh_r    <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      wc_r    <= wc_nxt;
      mask_r  <= mask_nxt;
      loops_r <= loops_nxt;
      xc_r    <= xc_nxt;
      yc_r    <= yc_nxt;
      xl_r    <= xl_nxt;
      xh_r    <= xh_nxt;
      yl_r    <= yl_nxt;
      yh_r    <= yh_nxt;
    end
  end

  // offsets against the centre held before this word
  always_comb begin
    dx_neg = x_pos < xc_r;
    dy_neg = y_pos < yc_r;
    dx_mag = dx_neg ? (xc_r - x_pos) : (x_pos - xc_r);
    dy_mag = dy_neg ? (yc_r - y_pos) : (y_pos - yc_r);
    dx_pos = !dx_neg && (dx_mag != '0);
    dy_pos = !dy_neg && (dy_mag != '0);
    x_ctr  = dx_mag < cfg.centre_tol;
    y_ctr  = dy_mag < cfg.centre_tol;
    x_far  = dx_mag > cfg.far_thresh;
    y_far  = dy_mag > cfg.far_thresh;
    if (x_ctr && dy_pos && y_far)
      dir_bit = DIR_TOP;
    else if (dx_pos && x_far && y_ctr)
      dir_bit = DIR_RIGHT;
    else if (x_ctr && dy_neg && y_far)
      dir_bit = DIR_DOWN;
    else if (dx_neg && x_far && y_ctr)
      dir_bit = DIR_LEFT;
    else
      dir_bit = '0;
  end

  always_comb begin
    mode_cur  = restart ? MODE_WARMUP : mode_r;
    wc_cur    = restart ? '0 : wc_r;
    mask_cur  = restart ? '0 : mask_r;
    loops_cur = restart ? '0 : loops_r;
    mode_nxt  = mode_cur;
    wc_nxt    = wc_cur;
    mask_nxt  = mask_cur;
    loops_nxt = loops_cur;
    xc_nxt = xc_r;
    yc_nxt = yc_r;
    xl_nxt = xl_r;
    xh_nxt = xh_r;
    yl_nxt = yl_r;
    yh_nxt = yh_r;
    mask_or = mask_cur | dir_bit;
    case (mode_cur)
      MODE_WARMUP: begin
        if (({1'b0, wc_cur} + 5'd1) >= {1'b0, cfg.warmup}) begin
          xc_nxt = x_pos;
          xl_nxt = x_pos;
          xh_nxt = x_pos;
          yc_nxt = y_pos;
          yl_nxt = y_pos;
          yh_nxt = y_pos;
          wc_nxt    = '0;
          mask_nxt  = '0;
          loops_nxt = '0;
          mode_nxt  = MODE_CAL;
        end else begin
          wc_nxt = wc_cur + 4'd1;
        end
      end
      MODE_CAL: begin
        if (x_pos > xh_r) xh_nxt = x_pos;
        if (x_pos < xl_r) xl_nxt = x_pos;
        if (y_pos > yh_r) yh_nxt = y_pos;
        if (y_pos < yl_r) yl_nxt = y_pos;
        if (mask_or == DIR_ALL) begin
          loops_nxt = loops_cur + 4'd1;
          mask_nxt  = '0;
        end else begin
          mask_nxt = mask_or;
        end
        if (loops_nxt >= cfg.loops_req)
          mode_nxt = MODE_RUN;
      end
      default: ;
    endcase
  end

  // job for the sequencer, ranges taken from the updated extremes
  always_comb begin
    job.phase = mode_nxt;
    job.loops = loops_nxt;
    job.mask  = mask_nxt;
    job.moved = (dx_mag > cfg.dead_zone) || (dy_mag > cfg.dead_zone);
    job.x.mag = dx_mag;
    job.x.neg = dx_neg;
    if (dx_pos)
      job.x.range = (xh_nxt > xc_r) ? (xh_nxt - xc_r) : '0;
    else
      job.x.range = (xc_r > xl_nxt) ? (xc_r - xl_nxt) : '0;
    job.x.zero = (job.x.range == '0) || (dx_mag == '0);
    job.y.mag = dy_mag;
    // pitch runs with its sign reversed
    job.y.neg = dy_pos;
    if (dy_pos)
      job.y.range = (yh_nxt > yc_r) ? (yh_nxt - yc_r) : '0;
    else
      job.y.range = (yc_r > yl_nxt) ? (yc_r - yl_nxt) : '0;
    job.y.zero = (job.y.range == '0) || (dy_mag == '0);
  end

endmodule

[rtl/jcam_div.sv]
// Shared restoring divider, two quotient bits per cycle.
// Depends on jcam_pkg.
module jcam_div
  import jcam_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [ANGLE_W-1:0]   dividend,
  input  logic [POS_W-1:0]     divisor,
  output logic                 busy,
  output logic                 done,
  output logic [ANGLE_W-1:0]   quotient
);

  logic [DIV_NUM_W-1:0] num_r, num_nxt;
  logic [POS_W-1:0]     rem_r, rem_nxt;
  logic [POS_W-1:0]     den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r, done_r;
  logic [POS_W:0]       r1, r2;
  logic [POS_W-1:0]     r1s;
  logic                 ge1, ge2;

  always_comb begin
    r1  = {rem_r, num_r[DIV_NUM_W-1]};
    ge1 = r1 >= {1'b0, den_r};
    r1s = ge1 ? POS_W'(r1 - {1'b0, den_r}) : r1[POS_W-1:0];
    r2  = {r1s, num_r[DIV_NUM_W-2]};
    ge2 = r2 >= {1'b0, den_r};
    rem_nxt = ge2 ? POS_W'(r2 - {1'b0, den_r}) : r2[POS_W-1:0];
    num_nxt = {num_r[DIV_NUM_W-3:0], ge1, ge2};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == {DIV_CNT_W{1'b1}}) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= {1'b0, dividend};
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = num_r[ANGLE_W-1:0];

endmodule

[rtl/joystick_calibrate_and_angle_map_unit.sv]
// Top level: config registers, angle sequencer around the shared divider, output word.
// Depends on jcam_pkg, jcam_track and jcam_div.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  in_x_position, in_y_position, in_restart
//   out      source     out_valid / out_stall out_phase, out_loops_done,
//                                            out_direction_seen, out_pitch_angle,
//                                            out_roll_angle, out_moved
//   cfg      sink       cfg_wr_en            cfg_index, cfg_data
//
// Outside running a word goes from idle to the output state and back; the output register
// loads there unless a held word is under out_stall. Running adds two divider passes (pitch,
// then roll) before the output state, each a start state and a wait state that takes the quotient.
// in_stall is high from accept until the result is moved to the output register.
// The output register holds a word under out_stall; a new input is taken meanwhile.
// Synchronous active-low reset clears control state and loads register defaults.
module joystick_calibrate_and_angle_map_unit
  import jcam_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [POS_W-1:0]          in_x_position,
  input  logic [POS_W-1:0]          in_y_position,
  input  logic                      in_restart,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_phase,
  output logic [CNT_W-1:0]          out_loops_done,
  output logic [CNT_W-1:0]          out_direction_seen,
  output logic signed [ANGLE_W-1:0] out_pitch_angle,
  output logic signed [ANGLE_W-1:0] out_roll_angle,
  output logic                      out_moved,
  input  logic                      cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  cfg_t               cfg_r;
  logic [FS_W-1:0]    full_scale_r;
  state_t             state_r, state_nxt;
  job_t               job, job_r;
  logic               accept;
  logic [ANGLE_W-1:0] pitch_r, roll_r;
  logic               out_valid_r;
  logic               out_load;
  logic               div_start, div_busy, div_done;
  logic [ANGLE_W-1:0] div_dividend, div_quotient;
  logic [POS_W-1:0]   div_divisor;
  axis_job_t          cur_axis;
  logic [ANGLE_W-1:0] angle_sat;

  function automatic logic [ANGLE_W-1:0] sat_angle(input logic [ANGLE_W-1:0] q,
                                                    input axis_job_t a);
    logic [ANGLE_W-1:0] m;
    begin
      if (a.zero) begin
        sat_angle = '0;
      end else if (a.neg) begin
        m = (q > ANGLE_NEG_MAX) ? ANGLE_NEG_MAX : q;
        sat_angle = ANGLE_W'(~m + 15'd1);
      end else begin
        sat_angle = (q > ANGLE_POS_MAX) ? ANGLE_POS_MAX : q;
      end
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.centre_tol <= RST_CENTRE_TOL;
      cfg_r.far_thresh <= RST_FAR_THRESH;
      cfg_r.dead_zone  <= RST_DEAD_ZONE;
      cfg_r.warmup     <= RST_WARMUP;
      cfg_r.loops_req  <= RST_LOOPS_REQ;
      full_scale_r     <= RST_FULL_SCALE;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_CENTRE_TOL: cfg_r.centre_tol <= cfg_data;
        CFG_FAR_THRESH: cfg_r.far_thresh <= cfg_data;
        CFG_FULL_SCALE: full_scale_r     <= cfg_data[FS_W-1:0];
        CFG_DEAD_ZONE:  cfg_r.dead_zone  <= cfg_data;
        CFG_WARMUP:     cfg_r.warmup     <= cfg_data[CNT_W-1:0];
        CFG_LOOPS_REQ:  cfg_r.loops_req  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept = in_valid && !in_stall;

  jcam_track u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .accept  (accept),
    .x_pos   (in_x_position),
    .y_pos   (in_y_position),
    .restart (in_restart),
    .job     (job)
  );

  always_ff @(posedge clk) begin
    if (accept)
      job_r <= job;
  end

  // pitch pass first, roll pass second
  assign cur_axis     = (state_r == ST_PITCH_GO || state_r == ST_PITCH_WAIT) ? job_r.y : job_r.x;
  assign div_dividend = ANGLE_W'(cur_axis.mag) * ANGLE_W'(full_scale_r);
  assign div_divisor  = cur_axis.range;
  assign angle_sat    = sat_angle(div_quotient, cur_axis);

  jcam_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n)
      state_r <= ST_IDLE;
    else
      state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    out_load  = 1'b0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid)
          state_nxt = (job.phase == MODE_RUN) ? ST_PITCH_GO : ST_OUT;
      end
      ST_PITCH_GO: begin
        div_start = 1'b1;
        state_nxt = ST_PITCH_WAIT;
      end
      ST_PITCH_WAIT: begin
        if (div_done)
          state_nxt = ST_ROLL_GO;
      end
      ST_ROLL_GO: begin
        div_start = 1'b1;
        state_nxt = ST_ROLL_WAIT;
      end
      ST_ROLL_WAIT: begin
        if (div_done)
          state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pitch_r <= '0;
      roll_r  <= '0;
    end else if (div_done && state_r == ST_PITCH_WAIT) begin
      pitch_r <= angle_sat;
    end else if (div_done && state_r == ST_ROLL_WAIT) begin
      roll_r <= angle_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (out_load)
      out_valid_r <= 1'b1;
    else if (!out_stall)
      out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_phase          <= job_r.phase;
      out_loops_done     <= job_r.loops;
      out_direction_seen <= job_r.mask;
      out_pitch_angle    <= pitch_r;
      out_roll_angle     <= roll_r;
      out_moved          <= job_r.moved;
    end
  end

  assign out_valid = out_valid_r;

  a_angles_only_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_phase != MODE_RUN) |-> (out_pitch_angle == '0) && (out_roll_angle == '0))
    else $error("angle given outside running phase");

  a_mask_never_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_direction_seen != DIR_ALL))
    else $error("direction word reported full instead of counting a loop");

  a_div_idle_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !div_busy)
    else $error("divider busy while taking a new word");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_PITCH_WAIT || state_r == ST_ROLL_WAIT))
    else $error("divider result arrived outside a wait state");

  a_load_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !out_load || (state_r == ST_OUT))
    else $error("output loaded without passing the output state");

endmodule

[tb/tb_top.sv]
// Testbench for joystick_calibrate_and_angle_map_unit: directed and random sample streams,
// every result word checked field by field against an in-bench model of the block.
// Depends on jcam_pkg and the unit's RTL; reads no files.
`timescale 1ns / 100ps

module tb_top;
  import jcam_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;
  localparam int RANDOM_WORDS = 1080;

  typedef struct {
    logic [1:0]                phase;
    logic [CNT_W-1:0]          loops;
    logic [CNT_W-1:0]          dirs;
    logic signed [ANGLE_W-1:0] pitch;
    logic signed [ANGLE_W-1:0] roll;
    logic                      moved;
  } joy_word_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [POS_W-1:0]          in_x_position = '0;
  logic [POS_W-1:0]          in_y_position = '0;
  logic                      in_restart = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [1:0]                out_phase;
  logic [CNT_W-1:0]          out_loops_done;
  logic [CNT_W-1:0]          out_direction_seen;
  logic signed [ANGLE_W-1:0] out_pitch_angle;
  logic signed [ANGLE_W-1:0] out_roll_angle;
  logic                      out_moved;
  logic                      cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  joystick_calibrate_and_angle_map_unit dut (.*);

  // model state and register copies
  mode_t            mode_m;
  logic [CNT_W-1:0] warm_cnt, loop_cnt, dir_mask;
  logic [POS_W-1:0] ctr_x, ctr_y, lo_x, hi_x, lo_y, hi_y;
  logic [POS_W-1:0] tol_r, far_r, dz_r;
  logic [FS_W-1:0]  fs_r;
  logic [CNT_W-1:0] warm_r, loops_r;

  joy_word_t pending_words[$];
  joy_word_t seen_w;
  int        bad_cnt = 0;
  int        words_sent = 0;
  int        burst_left = 0;
  int        stall_left = 0;
  int        stall_style = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic int mag_of(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [POS_W-1:0] clip8(int v);
    if (v < 0) return '0;
    if (v > 255) return '1;
    return POS_W'(v);
  endfunction

  function automatic logic [ANGLE_W-1:0] axis_degrees(int d, int ctr, int lo, int hi,
                                                       bit invert);
    int rng;
    int q;
    bit neg;
    if (d > 0) rng = (hi > ctr) ? hi - ctr : 0;
    else rng = (ctr > lo) ? ctr - lo : 0;
    if (rng == 0 || d == 0) return '0;
    q = mag_of(d) * int'(fs_r) / rng;
    neg = (d < 0) != invert;
    if (neg) begin
      if (q > int'(ANGLE_NEG_MAX)) q = int'(ANGLE_NEG_MAX);
      return ANGLE_W'(-q);
    end
    if (q > int'(ANGLE_POS_MAX)) q = int'(ANGLE_POS_MAX);
    return ANGLE_W'(q);
  endfunction

  // advances the model by one accepted sample and returns the word it should produce
  task automatic map_sample(input logic [POS_W-1:0] x, y, input logic rs,
                            output joy_word_t w);
    int dx, dy, tol, far;
    if (rs) begin
      mode_m = MODE_WARMUP;
      warm_cnt = '0;
      dir_mask = '0;
      loop_cnt = '0;
    end
    // offsets use the centre held before this sample
    dx = int'(x) - int'(ctr_x);
    dy = int'(y) - int'(ctr_y);
    tol = int'(tol_r);
    far = int'(far_r);
    w.pitch = '0;
    w.roll = '0;
    case (mode_m)
      MODE_WARMUP: begin
        if (int'(warm_cnt) + 1 >= int'(warm_r)) begin
          ctr_x = x; lo_x = x; hi_x = x;
          ctr_y = y; lo_y = y; hi_y = y;
          warm_cnt = '0;
          dir_mask = '0;
          loop_cnt = '0;
          mode_m = MODE_CAL;
        end else begin
          warm_cnt = warm_cnt + 1'b1;
        end
      end
      MODE_CAL: begin
        if (x > hi_x) hi_x = x;
        if (x < lo_x) lo_x = x;
        if (y > hi_y) hi_y = y;
        if (y < lo_y) lo_y = y;
        if (mag_of(dx) < tol && dy > far) dir_mask |= DIR_TOP;
        else if (dx > far && mag_of(dy) < tol) dir_mask |= DIR_RIGHT;
        else if (mag_of(dx) < tol && dy < -far) dir_mask |= DIR_DOWN;
        else if (dx < -far && mag_of(dy) < tol) dir_mask |= DIR_LEFT;
        if (dir_mask == DIR_ALL) begin
          loop_cnt += 1'b1;
          dir_mask = '0;
        end
        if (loop_cnt >= loops_r) mode_m = MODE_RUN;
      end
      default: ;
    endcase
    if (mode_m == MODE_RUN) begin
      w.pitch = axis_degrees(dy, int'(ctr_y), int'(lo_y), int'(hi_y), 1'b1);
      w.roll = axis_degrees(dx, int'(ctr_x), int'(lo_x), int'(hi_x), 1'b0);
    end
    w.phase = mode_m;
    w.loops = loop_cnt;
    w.dirs = dir_mask;
    w.moved = (mag_of(dx) > int'(dz_r)) || (mag_of(dy) > int'(dz_r));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_CENTRE_TOL: tol_r = val;
      CFG_FAR_THRESH: far_r = val;
      CFG_FULL_SCALE: fs_r = val[FS_W-1:0];
      CFG_DEAD_ZONE:  dz_r = val;
      CFG_WARMUP:     warm_r = val[CNT_W-1:0];
      CFG_LOOPS_REQ:  loops_r = val[CNT_W-1:0];
      default: ;
    endcase
  endtask

  // sender works in bursts; valid stays high across back-to-back words
  task automatic push_word(input logic [POS_W-1:0] x, y, input logic rs);
    joy_word_t w;
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 30);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x_position <= x;
    in_y_position <= y;
    in_restart <= rs;
    do @(posedge clk); while (in_stall);
    map_sample(x, y, rs, w);
    pending_words.push_back(w);
    words_sent++;
  endtask

  task automatic drain_words();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
  endtask

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      bad_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("result word arrived with nothing expected");
        bad_cnt++;
      end else begin
        seen_w = pending_words.pop_front();
        check_field("phase", 32'(seen_w.phase), 32'(out_phase));
        check_field("loops_done", 32'(seen_w.loops), 32'(out_loops_done));
        check_field("direction_seen", 32'(seen_w.dirs), 32'(out_direction_seen));
        check_field("pitch_angle", 32'(seen_w.pitch), 32'(out_pitch_angle));
        check_field("roll_angle", 32'(seen_w.roll), 32'(out_roll_angle));
        check_field("moved", 32'(seen_w.moved), 32'(out_moved));
      end
    end
  end

  // receiver: stretches of free flow, light, heavy and mostly-held stalling
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left = $urandom_range(8, 120);
    end
    stall_left--;
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 1);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // picks a point for a direction still missing from this circle
  task automatic aim_gesture(output logic [POS_W-1:0] x, y);
    logic [CNT_W-1:0] want;
    int start, side, reach, cx, cy, sx, sy, tol;
    start = $urandom_range(0, 3);
    want = DIR_TOP;
    for (int k = 3; k >= 0; k--) begin
      if ((dir_mask & (DIR_TOP << ((start + k) % 4))) == '0)
        want = DIR_TOP << ((start + k) % 4);
    end
    tol = int'(tol_r);
    side = (tol > 0) ? int'($urandom_range(0, 2 * (tol - 1))) - (tol - 1) : 0;
    reach = int'(far_r) + 1 + int'($urandom_range(0, 25));
    cx = int'(ctr_x);
    cy = int'(ctr_y);
    case (want)
      DIR_TOP: begin
        sx = cx + side;
        sy = cy + reach;
      end
      DIR_RIGHT: begin
        sx = cx + reach;
        sy = cy + side;
      end
      DIR_DOWN: begin
        sx = cx + side;
        sy = cy - reach;
      end
      default: begin
        sx = cx - reach;
        sy = cy + side;
      end
    endcase
    x = clip8(sx);
    y = clip8(sy);
  endtask

  // restart/warmup, calibration circles, then running samples
  task automatic play_session(input int run_len);
    logic [POS_W-1:0] x, y;
    logic rs;
    int budget;
    rs = (mode_m == MODE_RUN) || ($urandom_range(0, 3) == 0);
    while (rs || mode_m == MODE_WARMUP) begin
      if ((rs ? 1 : int'(warm_cnt) + 1) >= int'(warm_r)) begin
        // this word becomes the centre
        x = ($urandom_range(0, 4) == 0) ? POS_W'($urandom) : POS_W'($urandom_range(70, 185));
        y = ($urandom_range(0, 4) == 0) ? POS_W'($urandom) : POS_W'($urandom_range(70, 185));
      end else begin
        x = POS_W'($urandom);
        y = POS_W'($urandom);
      end
      push_word(x, y, rs);
      rs = 1'b0;
    end
    // sometimes stop partway so a later register write lands mid-calibration
    budget = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : 8 * (int'(loops_r) + 1) + 10;
    while (mode_m == MODE_CAL && budget > 0) begin
      case ($urandom_range(0, 9))
        0: begin
          x = POS_W'($urandom);
          y = POS_W'($urandom);
        end
        1: begin
          x = clip8(int'(ctr_x) + int'($urandom_range(0, 6)) - 3);
          y = clip8(int'(ctr_y) + int'($urandom_range(0, 6)) - 3);
        end
        default: aim_gesture(x, y);
      endcase
      push_word(x, y, 1'b0);
      budget--;
    end
    for (int i = 0; i < run_len; i++) begin
      case ($urandom_range(0, 19))
        0: begin
          x = ctr_x;
          y = ctr_y;
        end
        1: begin
          x = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
          y = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
        end
        2, 3, 4, 5: begin
          x = POS_W'($urandom);
          y = POS_W'($urandom);
        end
        default: begin
          x = POS_W'($urandom_range(lo_x, hi_x));
          y = POS_W'($urandom_range(lo_y, hi_y));
        end
      endcase
      push_word(x, y, $urandom_range(0, 79) == 0);
    end
  endtask

  function automatic int pick_setting(int lo, int hi, int tlo, int thi);
    case ($urandom_range(0, 9))
      0: return lo;
      1: return hi;
      default: return $urandom_range(tlo, thi);
    endcase
  endfunction

  // reset register values, default warmup, one circle to reach running
  task automatic test_basic_calibration();
    write_reg(CFG_LOOPS_REQ, 8'd1);
    cfg_wr_en <= 1'b0;
    for (int i = 0; i < 9; i++) push_word(i[0] ? 8'hFF : 8'h00, i[1] ? 8'hFF : 8'h00, 1'b0);
    push_word(8'd120, 8'd120, 1'b0);
    push_word(8'd122, 8'd200, 1'b0);
    push_word(8'd200, 8'd118, 1'b0);
    push_word(8'd118, 8'd40, 1'b0);
    push_word(8'd40, 8'd121, 1'b0);
    push_word(8'd255, 8'd0, 1'b0);
    push_word(8'd0, 8'd255, 1'b0);
    push_word(8'd121, 8'd119, 1'b0);
  endtask

  // zero warmup and loops, unit ranges for saturation, zero ranges, direction priority
  task automatic test_saturation_and_priority();
    drain_words();
    write_reg(CFG_FULL_SCALE, 8'd90);
    write_reg(CFG_WARMUP, 8'd0);
    write_reg(CFG_LOOPS_REQ, 8'd0);
    write_reg(CFG_DEAD_ZONE, 8'd0);
    write_reg(CFG_CENTRE_TOL, 8'd255);
    write_reg(CFG_FAR_THRESH, 8'd0);
    write_reg(CFG_SPARE_6, 8'hFF);
    write_reg(CFG_SPARE_7, 8'hFF);
    cfg_wr_en <= 1'b0;
    push_word(8'd50, 8'd200, 1'b1);
    push_word(8'd51, 8'd199, 1'b0);
    push_word(8'd255, 8'd0, 1'b0);
    push_word(8'd0, 8'd255, 1'b0);
    push_word(8'd200, 8'd50, 1'b1);
    push_word(8'd199, 8'd51, 1'b0);
    push_word(8'd0, 8'd255, 1'b0);
    push_word(8'd200, 8'd50, 1'b0);
  endtask

  // loop target dropped below the loops already counted
  task automatic test_loops_lowered();
    drain_words();
    write_reg(CFG_CENTRE_TOL, 8'd5);
    write_reg(CFG_FAR_THRESH, 8'd70);
    write_reg(CFG_FULL_SCALE, 8'd60);
    write_reg(CFG_DEAD_ZONE, 8'd10);
    write_reg(CFG_WARMUP, 8'd1);
    write_reg(CFG_LOOPS_REQ, 8'd2);
    cfg_wr_en <= 1'b0;
    push_word(8'd128, 8'd128, 1'b1);
    push_word(8'd129, 8'd220, 1'b0);
    push_word(8'd220, 8'd127, 1'b0);
    push_word(8'd127, 8'd30, 1'b0);
    push_word(8'd30, 8'd128, 1'b0);
    drain_words();
    write_reg(CFG_LOOPS_REQ, 8'd0);
    cfg_wr_en <= 1'b0;
    push_word(8'd128, 8'd128, 1'b0);
    push_word(8'd250, 8'd5, 1'b0);
  endtask

  task automatic test_random_sessions();
    int stop_at;
    stop_at = words_sent + RANDOM_WORDS;
    while (words_sent < stop_at) begin
      drain_words();
      write_reg(CFG_CENTRE_TOL, CFG_DATA_W'(pick_setting(0, 255, 2, 20)));
      write_reg(CFG_FAR_THRESH, CFG_DATA_W'(pick_setting(0, 255, 20, 90)));
      write_reg(CFG_FULL_SCALE, CFG_DATA_W'(pick_setting(0, 90, 1, 90)));
      write_reg(CFG_DEAD_ZONE, CFG_DATA_W'(pick_setting(0, 255, 0, 40)));
      write_reg(CFG_WARMUP, CFG_DATA_W'(pick_setting(0, 15, 1, 5)));
      write_reg(CFG_LOOPS_REQ, CFG_DATA_W'(pick_setting(0, 15, 1, 3)));
      cfg_wr_en <= 1'b0;
      repeat ($urandom_range(1, 3)) play_session($urandom_range(4, 40));
    end
  endtask

  initial begin
    mode_m = MODE_WARMUP;
    warm_cnt = '0;
    loop_cnt = '0;
    dir_mask = '0;
    ctr_x = '0; ctr_y = '0;
    lo_x = '0; hi_x = '0; lo_y = '0; hi_y = '0;
    tol_r = RST_CENTRE_TOL;
    far_r = RST_FAR_THRESH;
    fs_r = RST_FULL_SCALE;
    dz_r = RST_DEAD_ZONE;
    warm_r = RST_WARMUP;
    loops_r = RST_LOOPS_REQ;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_calibration();
    test_saturation_and_priority();
    test_loops_lowered();
    test_random_sessions();
    drain_words();
    repeat (40) @(posedge clk);
    if (bad_cnt == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

[joystick_calibrate_and_angle_map_unit.f]
rtl/jcam_pkg.sv
rtl/jcam_track.sv
rtl/jcam_div.sv
rtl/joystick_calibrate_and_angle_map_unit.sv
tb/tb_top.sv
